/* rtl/core/exponential_note_envelope_macros.svh */
// Assertion macros for the exponential note envelope.
`ifndef EXPONENTIAL_NOTE_ENVELOPE_MACROS_SVH
`define EXPONENTIAL_NOTE_ENVELOPE_MACROS_SVH

`ifndef SYNTHESIS
`define NENV_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("envelope check failed");
`define NENV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("envelope check failed");
`else
`define NENV_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define NENV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/nenv_pkg.sv */
// Shared types, register indexes and exponent table builder for the note envelope.
package nenv_pkg;

   localparam int RATE_FRAC      = 24;
   localparam int RATE_BITS      = 24;
   localparam int TIME_BITS      = 32;
   localparam int OFFSET_BITS    = 31;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_IDX_BITS   = 3;
   localparam int MAX_TABLE_BITS = 12;

   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_DECAY   = 2'd1,
      PH_RELEASE = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_NOTE_START     = 3'd0,
      CSR_PEAK_LEVEL     = 3'd1,
      CSR_SUSTAIN_LEVEL  = 3'd2,
      CSR_RELEASE_OFFSET = 3'd3,
      CSR_ATTACK_RATE    = 3'd4,
      CSR_DECAY_RATE     = 3'd5,
      CSR_RELEASE_RATE   = 3'd6
   } csr_index_type;

   localparam logic [CSR_DATA_BITS-1:0] RST_NOTE_START     = 32'd0;
   localparam logic [CSR_DATA_BITS-1:0] RST_PEAK_LEVEL     = 32'd65535;
   localparam logic [CSR_DATA_BITS-1:0] RST_SUSTAIN_LEVEL  = 32'd32768;
   localparam logic [CSR_DATA_BITS-1:0] RST_RELEASE_OFFSET = 32'd48000;
   localparam logic [CSR_DATA_BITS-1:0] RST_RATE           = 32'd65536;

   // bitwise integer square root, 32 result bits
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] v;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      v = x;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-idx/2^tbits) in Q1.lbits, built from Q0.32 square-root factors
   function automatic logic [63:0] exp_rom_entry(input int idx, input int tbits,
                                                 input int lbits);
      logic [63:0] root [MAX_TABLE_BITS+1];
      logic [63:0] acc;
      root[0] = '0;
      root[1] = isqrt64(64'h8000_0000_0000_0000);
      for (int k = 2; k <= tbits; k++) begin
         root[k] = isqrt64(root[k-1] << 32);
      end
      acc = 64'h1_0000_0000;
      for (int j = 0; j < tbits; j++) begin
         if (((idx >> j) & 1) != 0) begin
            acc = (acc * root[tbits-j]) >> 32;
         end
      end
      return (acc + (64'd1 << (31 - lbits))) >> (32 - lbits);
   endfunction

endpackage

/* rtl/core/exponential_note_envelope.sv */
// Exponential note envelope: level and phase at an absolute sample time.
// Each accepted item runs through stage registers 1 to 7; rsp_strobe marks its result.
// Throughput: one item per cycle through the seven-stage datapath, busy low outside reset.
// Two rate multipliers (24x32 and 24x31) in stage 3; three level multipliers, two in stage 5 and one in stage 7.
// Reset clears the stage valid bits and loads the register defaults; busy is high in reset.
`include "exponential_note_envelope_macros.svh"

module exponential_note_envelope #(
   parameter int LEVEL_BITS     = 16,
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [nenv_pkg::TIME_BITS-1:0]          req_sample_time,
   output logic                                    rsp_strobe,
   output logic [LEVEL_BITS-1:0]                   rsp_level,
   output nenv_pkg::phase_type                     rsp_phase,
   input  logic                                    csr_write,
   input  logic [nenv_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [nenv_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import nenv_pkg::*;

   localparam int ROM_SIZE = 1 << EXP_TABLE_BITS;
   localparam int E_BITS   = LEVEL_BITS + 1;
   localparam int Y_BITS   = RATE_BITS + TIME_BITS;
   localparam int IP_BITS  = Y_BITS - RATE_FRAC;
   localparam int SH_BITS  = $clog2(LEVEL_BITS);
   localparam int P_BITS   = LEVEL_BITS + E_BITS;
   localparam logic [P_BITS:0] ROUND_UP = (P_BITS+1)'((64'd1 << LEVEL_BITS) - 64'd1);

   // configuration
   logic [TIME_BITS-1:0]   note_start_ff;
   logic [LEVEL_BITS-1:0]  peak_ff;
   logic [LEVEL_BITS-1:0]  sustain_ff;
   logic [OFFSET_BITS-1:0] rel_offset_ff;
   logic [RATE_BITS-1:0]   attack_rate_ff;
   logic [RATE_BITS-1:0]   decay_rate_ff;
   logic [RATE_BITS-1:0]   release_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_start_ff   <= RST_NOTE_START;
         peak_ff         <= LEVEL_BITS'(RST_PEAK_LEVEL);
         sustain_ff      <= LEVEL_BITS'(RST_SUSTAIN_LEVEL);
         rel_offset_ff   <= OFFSET_BITS'(RST_RELEASE_OFFSET);
         attack_rate_ff  <= RATE_BITS'(RST_RATE);
         decay_rate_ff   <= RATE_BITS'(RST_RATE);
         release_rate_ff <= RATE_BITS'(RST_RATE);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_NOTE_START:     note_start_ff   <= csr_data;
            CSR_PEAK_LEVEL:     peak_ff         <= LEVEL_BITS'(csr_data[15:0]);
            CSR_SUSTAIN_LEVEL:  sustain_ff      <= LEVEL_BITS'(csr_data[15:0]);
            CSR_RELEASE_OFFSET: rel_offset_ff   <= csr_data[OFFSET_BITS-1:0];
            CSR_ATTACK_RATE:    attack_rate_ff  <= csr_data[RATE_BITS-1:0];
            CSR_DECAY_RATE:     decay_rate_ff   <= csr_data[RATE_BITS-1:0];
            CSR_RELEASE_RATE:   release_rate_ff <= csr_data[RATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // exponent table
   logic [E_BITS-1:0] rom_tbl [ROM_SIZE];
   for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
      assign rom_tbl[g] = E_BITS'(exp_rom_entry(g, EXP_TABLE_BITS, LEVEL_BITS));
   end

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff} <= '0;
      end else begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff} <=
            {accept, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff};
      end
   end

   // stage 1: distance from note start
   logic                 attack1_ff, attack1_in;
   logic [TIME_BITS-1:0] diff1_ff, diff1_in;
   always_comb begin
      attack1_in = req_sample_time < note_start_ff;
      diff1_in   = attack1_in ? note_start_ff - req_sample_time
                              : req_sample_time - note_start_ff;
   end

   // stage 2: phase, rate and tick count
   phase_type            ph2_ff, ph2_in;
   logic [RATE_BITS-1:0] rate2_ff, rate2_in;
   logic [TIME_BITS-1:0] ticks2_ff, ticks2_in;
   always_comb begin
      priority if (attack1_ff) begin
         ph2_in    = PH_ATTACK;
         rate2_in  = attack_rate_ff;
         ticks2_in = diff1_ff;
      end else if (diff1_ff <= {1'b0, rel_offset_ff}) begin
         ph2_in    = PH_DECAY;
         rate2_in  = decay_rate_ff;
         ticks2_in = diff1_ff;
      end else begin
         ph2_in    = PH_RELEASE;
         rate2_in  = release_rate_ff;
         ticks2_in = diff1_ff - {1'b0, rel_offset_ff};
      end
   end

   // stage 3: exponents in log2 units
   phase_type         ph3_ff;
   logic [Y_BITS-1:0] ym3_ff, ym3_in, yr3_ff, yr3_in;
   always_comb begin
      ym3_in = Y_BITS'(rate2_ff) * Y_BITS'(ticks2_ff);
      yr3_in = Y_BITS'(decay_rate_ff) * Y_BITS'(rel_offset_ff);
   end

   // stage 4: table lookup and integer shift
   phase_type                    ph4_ff;
   logic [E_BITS-1:0]            em4_ff, em4_in, er4_ff, er4_in;
   logic [LEVEL_BITS-1:0]        psd4_ff, psd4_in;
   logic                         up4_ff, up4_in;
   logic [EXP_TABLE_BITS-1:0]    idx_m, idx_r;
   always_comb begin
      idx_m  = ym3_ff[RATE_FRAC-1 -: EXP_TABLE_BITS];
      idx_r  = yr3_ff[RATE_FRAC-1 -: EXP_TABLE_BITS];
      em4_in = (ym3_ff[Y_BITS-1:RATE_FRAC] >= IP_BITS'(LEVEL_BITS)) ? '0
               : rom_tbl[idx_m] >> ym3_ff[RATE_FRAC +: SH_BITS];
      er4_in = (yr3_ff[Y_BITS-1:RATE_FRAC] >= IP_BITS'(LEVEL_BITS)) ? '0
               : rom_tbl[idx_r] >> yr3_ff[RATE_FRAC +: SH_BITS];
      up4_in  = peak_ff >= sustain_ff;
      psd4_in = up4_in ? peak_ff - sustain_ff : sustain_ff - peak_ff;
   end

   // stage 5: amplitude products
   phase_type         ph5_ff;
   logic [E_BITS-1:0] em5_ff;
   logic              up5_ff;
   logic [P_BITS-1:0] pm5_ff, pm5_in, pr5_ff, pr5_in;
   always_comb begin
      pm5_in = P_BITS'(ph4_ff == PH_ATTACK ? peak_ff : psd4_ff) * P_BITS'(em4_ff);
      pr5_in = P_BITS'(psd4_ff) * P_BITS'(er4_ff);
   end

   // stage 6: decay level toward sustain, release start level
   function automatic logic [LEVEL_BITS-1:0] decay_mix(input logic [P_BITS-1:0] p,
                                                      input logic up,
                                                      input logic [LEVEL_BITS-1:0] sus);
      logic [P_BITS:0] sum;
      sum = {1'b0, p} + ROUND_UP;
      return up ? sus + LEVEL_BITS'(p >> LEVEL_BITS)
                : sus - LEVEL_BITS'(sum >> LEVEL_BITS);
   endfunction

   phase_type             ph6_ff;
   logic [E_BITS-1:0]     em6_ff;
   logic [LEVEL_BITS-1:0] lvl6_ff, lvl6_in, r06_ff, r06_in;
   always_comb begin
      lvl6_in = (ph5_ff == PH_ATTACK) ? LEVEL_BITS'(pm5_ff >> LEVEL_BITS)
                                      : decay_mix(pm5_ff, up5_ff, sustain_ff);
      r06_in  = decay_mix(pr5_ff, up5_ff, sustain_ff);
   end

   // stage 7: release scaling, output register
   logic [P_BITS-1:0]     prel;
   logic [LEVEL_BITS-1:0] level7_ff, level7_in;
   phase_type             ph7_ff;
   always_comb begin
      prel      = P_BITS'(r06_ff) * P_BITS'(em6_ff);
      level7_in = (ph6_ff == PH_RELEASE) ? LEVEL_BITS'(prel >> LEVEL_BITS) : lvl6_ff;
   end

   always_ff @(posedge clock) begin
      attack1_ff <= attack1_in;
      diff1_ff   <= diff1_in;
      ph2_ff     <= ph2_in;
      rate2_ff   <= rate2_in;
      ticks2_ff  <= ticks2_in;
      ph3_ff     <= ph2_ff;
      ym3_ff     <= ym3_in;
      yr3_ff     <= yr3_in;
      ph4_ff     <= ph3_ff;
      em4_ff     <= em4_in;
      er4_ff     <= er4_in;
      psd4_ff    <= psd4_in;
      up4_ff     <= up4_in;
      ph5_ff     <= ph4_ff;
      em5_ff     <= em4_ff;
      up5_ff     <= up4_ff;
      pm5_ff     <= pm5_in;
      pr5_ff     <= pr5_in;
      ph6_ff     <= ph5_ff;
      em6_ff     <= em5_ff;
      lvl6_ff    <= lvl6_in;
      r06_ff     <= r06_in;
      ph7_ff     <= ph6_ff;
      level7_ff  <= level7_in;
   end

   assign rsp_strobe = v7_ff;
   assign rsp_level  = level7_ff;
   assign rsp_phase  = ph7_ff;

   `NENV_ASSERT_IMPL(a_attack_below_peak, clock, reset,
      rsp_strobe && rsp_phase == PH_ATTACK, rsp_level <= peak_ff)
   `NENV_ASSERT_IMPL(a_decay_in_range, clock, reset,
      rsp_strobe && rsp_phase == PH_DECAY && peak_ff >= sustain_ff,
      rsp_level >= sustain_ff && rsp_level <= peak_ff)
   `NENV_ASSERT_NEXT(a_release_below_start, clock, reset,
      v6_ff && ph6_ff == PH_RELEASE, rsp_level <= $past(r06_ff))

endmodule

/* test/tb.sv */
// Self-checking testbench for the exponential note envelope: directed and random evaluation times.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nenv_pkg::*;

   localparam int LVL_BITS = 16;
   localparam int TBL_BITS = 8;
   localparam int PIPE_LATENCY = 7;
   localparam int RANDOM_PHASES = 14;
   localparam int ITEMS_PER_PHASE = 75;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [LVL_BITS-1:0] level;
      phase_type phase;
   } envelope_point_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [TIME_BITS-1:0] req_sample_time;
   logic rsp_strobe;
   logic [LVL_BITS-1:0] rsp_level;
   phase_type rsp_phase;
   logic csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   // envelope settings as the block should hold them
   logic [31:0] note_start;
   logic [15:0] peak_level;
   logic [15:0] sustain_level;
   logic [30:0] release_offset;
   logic [23:0] attack_rate;
   logic [23:0] decay_rate;
   logic [23:0] release_rate;

   logic [LVL_BITS:0] pow2_table [1 << TBL_BITS];
   envelope_point_type expected_points [$];
   int mismatches = 0;

   exponential_note_envelope #(
      .LEVEL_BITS    (LVL_BITS),
      .EXP_TABLE_BITS(TBL_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample_time(req_sample_time),
      .rsp_strobe     (rsp_strobe),
      .rsp_level      (rsp_level),
      .rsp_phase      (rsp_phase),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // floor square root, one result bit at a time
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] cand;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if (cand * cand <= x) begin
            r = cand;
         end
      end
      return r;
   endfunction

   // 2^(-i/256) table in Q1.16, entry 0 is exactly 1.0
   task automatic fill_pow2_table();
      logic [63:0] roots [TBL_BITS+1];
      logic [63:0] acc;
      roots[0] = '0;
      roots[1] = floor_sqrt(64'd1 << 63);
      for (int k = 2; k <= TBL_BITS; k++) begin
         roots[k] = floor_sqrt(roots[k-1] << 32);
      end
      for (int i = 0; i < (1 << TBL_BITS); i++) begin
         acc = 64'd1 << 32;
         for (int j = 0; j < TBL_BITS; j++) begin
            if (i[j]) begin
               acc = (acc * roots[TBL_BITS-j]) >> 32;
            end
         end
         pow2_table[i] = (LVL_BITS+1)'((acc + (64'd1 << (31 - LVL_BITS))) >> (32 - LVL_BITS));
      end
   endtask

   function automatic logic [63:0] pow2_neg(input logic [23:0] rate, input logic [63:0] ticks);
      logic [63:0] y;
      logic [63:0] whole;
      y = 64'(rate) * ticks;
      whole = y >> RATE_FRAC;
      if (whole >= LVL_BITS) begin
         return 64'd0;
      end
      return 64'(pow2_table[y[RATE_FRAC-1 -: TBL_BITS]]) >> whole;
   endfunction

   function automatic logic [63:0] decayed_level(input logic [63:0] ticks);
      logic [63:0] e;
      e = pow2_neg(decay_rate, ticks);
      if (peak_level >= sustain_level) begin
         return 64'(sustain_level) + ((64'(peak_level - sustain_level) * e) >> LVL_BITS);
      end
      return 64'(sustain_level)
         - ((64'(sustain_level - peak_level) * e + 64'hFFFF) >> LVL_BITS);
   endfunction

   function automatic envelope_point_type envelope_at(input logic [31:0] t);
      envelope_point_type p;
      logic [63:0] d;
      logic [63:0] lvl;
      if (t < note_start) begin
         lvl = (64'(peak_level) * pow2_neg(attack_rate, 64'(note_start - t))) >> LVL_BITS;
         p.phase = PH_ATTACK;
      end else begin
         d = 64'(t) - 64'(note_start);
         if (d <= 64'(release_offset)) begin
            lvl = decayed_level(d);
            p.phase = PH_DECAY;
         end else begin
            lvl = (decayed_level(64'(release_offset))
                   * pow2_neg(release_rate, d - 64'(release_offset))) >> LVL_BITS;
            p.phase = PH_RELEASE;
         end
      end
      p.level = lvl[LVL_BITS-1:0];
      return p;
   endfunction

   always @(posedge clock) begin
      envelope_point_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_points.size() == 0) begin
            $error("unexpected item: level %0d phase %0d", rsp_level, rsp_phase);
            mismatches++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_level !== want.level) begin
               $error("level: expected %0d, actual %0d", want.level, rsp_level);
               mismatches++;
            end
            if (rsp_phase !== want.phase) begin
               $error("phase: expected %0d, actual %0d", want.phase, rsp_phase);
               mismatches++;
            end
         end
      end
   end

   task automatic send_item(input logic [31:0] t);
      start <= 1'b1;
      req_sample_time <= t;
      do @(posedge clock); while (busy !== 1'b0);
      expected_points.push_back(envelope_at(t));
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      for (int i = 0; i < 20 * PIPE_LATENCY && expected_points.size() != 0; i++) begin
         @(posedge clock);
      end
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (expected_points.size() != 0) begin
         $error("%0d items never came out", expected_points.size());
         mismatches++;
         expected_points.delete();
      end
   endtask

   // leaves csr_write high; program_settings lowers it
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_NOTE_START:     note_start = value;
         CSR_PEAK_LEVEL:     peak_level = value[15:0];
         CSR_SUSTAIN_LEVEL:  sustain_level = value[15:0];
         CSR_RELEASE_OFFSET: release_offset = value[30:0];
         CSR_ATTACK_RATE:    attack_rate = value[23:0];
         CSR_DECAY_RATE:     decay_rate = value[23:0];
         CSR_RELEASE_RATE:   release_rate = value[23:0];
         default: ;
      endcase
   endtask

   task automatic program_settings(input logic [31:0] ns, input logic [31:0] peak,
                                   input logic [31:0] sus, input logic [31:0] off,
                                   input logic [31:0] atk, input logic [31:0] dec,
                                   input logic [31:0] rel);
      write_reg(CSR_NOTE_START, ns);
      write_reg(CSR_PEAK_LEVEL, peak);
      write_reg(CSR_SUSTAIN_LEVEL, sus);
      write_reg(CSR_RELEASE_OFFSET, off);
      write_reg(CSR_ATTACK_RATE, atk);
      write_reg(CSR_DECAY_RATE, dec);
      write_reg(CSR_RELEASE_RATE, rel);
      csr_write <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_item(32'd0);
      send_item(32'd48000);
      send_item(32'd48001);
      send_item(32'hFFFF_FFFF);
      drain_results();
   endtask

   task automatic test_phase_edges();
      write_reg(CSR_UNUSED, $urandom);
      program_settings(32'd1000, {16'hA5A5, 16'd50000}, 32'd20000, {1'b1, 31'd100},
                       32'h0010_0000, 32'h0004_0000, {8'hFF, 24'h40_0000});
      send_item(32'd0);
      send_item(32'd999);
      send_item(32'd1000);
      send_item(32'd1050);
      send_item(32'd1100);
      send_item(32'd1101);
      send_item(32'd1200);
      send_item(32'hFFFF_FFFF);
      drain_results();
   endtask

   task automatic test_rising_decay();
      program_settings(32'd1000, 32'd100, 32'd60000, 32'd100,
                       32'h0010_0000, 32'h0004_0000, 32'h0040_0000);
      send_item(32'd1000);
      send_item(32'd1010);
      send_item(32'd1100);
      send_item(32'd1101);
      drain_results();
   endtask

   task automatic test_zero_rates();
      program_settings(32'd1000, 32'd40000, 32'd10000, 32'd100, 32'd0, 32'd0, 32'd0);
      send_item(32'd0);
      send_item(32'd1050);
      send_item(32'd5000);
      drain_results();
   endtask

   task automatic test_extremes();
      program_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF,
                       32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
      send_item(32'd0);
      send_item(32'hFFFF_FFFE);
      send_item(32'hFFFF_FFFF);
      drain_results();
      program_settings(32'd0, 32'd65535, 32'd0, 32'd0,
                       32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
      send_item(32'd0);
      send_item(32'd1);
      send_item(32'd17);
      drain_results();
   endtask

   function automatic logic [23:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFF_FFFF;
         2: return 24'($urandom_range(0, 1 << 12));
         3: return 24'($urandom_range(0, 1 << 16));
         4: return 24'($urandom_range(0, 1 << 20));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_level();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_time();
      logic [31:0] span;
      span = $urandom >> $urandom_range(0, 31);
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return note_start - 32'($urandom_range(1, 64));
         2: return note_start - span;
         3: return note_start + 32'($urandom_range(0, 64));
         4: return note_start + release_offset + 32'($urandom_range(0, 4)) - 32'd2;
         5: return note_start + release_offset + span;
         6: return note_start + span;
         default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      endcase
   endfunction

   task automatic test_random_envelopes();
      logic [31:0] ns;
      logic [31:0] off;
      int burst_left;
      bit steady;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0: ns = 32'd0;
            1: ns = 32'hFFFF_FFFF;
            2: ns = $urandom_range(0, 1 << 20);
            default: ns = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0: off = 32'd0;
            1: off = 32'h7FFF_FFFF;
            2: off = $urandom_range(0, 1000);
            default: off = $urandom;
         endcase
         drain_results();
         program_settings(ns, {16'($urandom), pick_level()}, {16'($urandom), pick_level()},
                          off, {8'($urandom), pick_rate()}, {8'($urandom), pick_rate()},
                          {8'($urandom), pick_rate()});
         steady = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_item(pick_time());
            burst_left--;
            if (!steady && burst_left == 0) begin
               pause_sender($urandom_range(0, 3) == 0 ? $urandom_range(1, 12)
                                                      : $urandom_range(1, 3));
               burst_left = $urandom_range(1, 24);
            end
         end
      end
      drain_results();
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_sample_time <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      note_start = RST_NOTE_START;
      peak_level = RST_PEAK_LEVEL[15:0];
      sustain_level = RST_SUSTAIN_LEVEL[15:0];
      release_offset = RST_RELEASE_OFFSET[30:0];
      attack_rate = RST_RATE[23:0];
      decay_rate = RST_RATE[23:0];
      release_rate = RST_RATE[23:0];
      fill_pow2_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_phase_edges();
      test_rising_decay();
      test_zero_rates();
      test_extremes();
      test_random_envelopes();

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/nenv_pkg.sv
rtl/core/exponential_note_envelope.sv
test/tb.sv
